/* design/sorted_list_merge_unit_defines.svh */
// assertion macros shared by the sorted list merge unit
// no dependencies; included by files that carry concurrent checks
`ifndef SORTED_LIST_MERGE_UNIT_DEFINES_SVH
`define SORTED_LIST_MERGE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SLM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted list merge check failed");

// next-cycle implication, disabled during reset
`define SLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted list merge check failed");

`endif

/* design/slm_pkg.sv */
// shared constants and types for the sorted list merge unit
// no dependencies
package slm_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int DATA_W     = 32;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int TOT_W      = CNT_W + 1;

  localparam logic [1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [1:0] KIND_MERGE       = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  // read control and completion from the sequencer to the storage
  typedef struct packed {
    logic              first_en;
    logic [ADDR_W-1:0] first_addr;
    logic              second_en;
    logic [ADDR_W-1:0] second_addr;
    logic              done;
  } rd_ctl_t;

endpackage

/* design/slm_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/slm_seq.sv */
// merge sequencer: head compare, read index control and output register
// depends on slm_pkg
module slm_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [slm_pkg::CNT_W-1:0]     first_count,
  input  logic [slm_pkg::CNT_W-1:0]     second_count,
  input  logic                          dropped,
  input  logic [slm_pkg::DATA_W-1:0]    head_first,
  input  logic [slm_pkg::DATA_W-1:0]    head_second,
  input  logic                          out_ready,
  output slm_pkg::rd_ctl_t              rd_ctl,
  output logic                          busy,
  output logic                          out_valid,
  output logic signed [slm_pkg::DATA_W-1:0] merged_value,
  output logic                          from_second,
  output logic                          last,
  output logic                          overflow
);
  import slm_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] ia, ib;
  logic [TOT_W-1:0] total, taken;
  logic             avail_first, avail_second, take_second, pick_last, step;
  logic [CNT_W-1:0] ia_inc, ib_inc;

  assign total        = TOT_W'(first_count) + TOT_W'(second_count);
  assign taken        = TOT_W'(ia) + TOT_W'(ib) + TOT_W'(1);
  assign avail_first  = ia < first_count;
  assign avail_second = ib < second_count;
  assign ia_inc       = ia + CNT_W'(1);
  assign ib_inc       = ib + CNT_W'(1);
  assign pick_last    = taken == total;
  assign busy         = state == ST_MERGE;
  assign step         = busy && (!out_valid || out_ready);

  // first list wins ties
  always_comb begin
    if (avail_first && avail_second) begin
      take_second = !($signed(head_first) <= $signed(head_second));
    end else begin
      take_second = !avail_first;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (step && pick_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // read requests: prime both heads at start, refill the consumed head
  always_comb begin
    rd_ctl             = '0;
    rd_ctl.first_addr  = ia_inc[ADDR_W-1:0];
    rd_ctl.second_addr = ib_inc[ADDR_W-1:0];
    unique case (state)
      ST_IDLE: begin
        rd_ctl.first_en    = start;
        rd_ctl.second_en   = start;
        rd_ctl.first_addr  = '0;
        rd_ctl.second_addr = '0;
      end
      ST_MERGE: begin
        rd_ctl.first_en  = step && !take_second;
        rd_ctl.second_en = step && take_second;
        rd_ctl.done      = step && pick_last;
      end
      default: rd_ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      ia        <= '0;
      ib        <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        ia <= '0;
        ib <= '0;
      end else if (step) begin
        if (take_second) begin
          ib <= ib_inc;
        end else begin
          ia <= ia_inc;
        end
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      merged_value <= take_second ? head_second : head_first;
      from_second  <= take_second;
      last         <= pick_last;
      overflow     <= dropped;
    end
  end

endmodule

/* design/sorted_list_merge_unit.sv */
// sorted list merge unit: usage
// two valid/ready channels. input transactions carry kind and value:
// kind 0 appends value to the first list, kind 1 to the second list,
// kind 2 merges both lists, kind 3 is taken and ignored.
// an append returns nothing; an append to a full
// list is dropped and raises a sticky overflow flag.
// a merge of n elements returns n output transactions in non-decreasing
// signed order, ties going to the first list, the final one marked last.
// each result carries the overflow flag; afterwards both lists and the
// flag are cleared. a merge of two empty lists returns nothing.
// the first result passes the ram read register, then the output register,
// then one per cycle while the receiver is ready: each step reads the next
// head from the list ram it consumed.
// the input channel is held off (in_ready low) for the whole merge.
// a stalled receiver freezes the merge; the ram heads hold until taken.
// reset (synchronous, active high) empties both lists and clears the
// flag; list storage itself is not cleared and needs no sweep.
// depends on slm_pkg, slm_seq, slm_ram and the assertion macro header
`include "sorted_list_merge_unit_defines.svh"

module sorted_list_merge_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        kind,
  input  logic signed [slm_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [slm_pkg::DATA_W-1:0] merged_value,
  output logic                              from_second,
  output logic                              last,
  output logic                              overflow
);
  import slm_pkg::*;

  logic [CNT_W-1:0]  first_count, second_count;
  logic              dropped;
  logic              accept, first_full, second_full;
  logic              load_first, load_second, merge_go, merge_empty;
  logic [DATA_W-1:0] head_first, head_second;
  logic              busy;
  rd_ctl_t           rd_ctl;

  assign in_ready    = !busy;
  assign accept      = in_valid && in_ready;
  assign first_full  = first_count >= CNT_W'(LIST_DEPTH);
  assign second_full = second_count >= CNT_W'(LIST_DEPTH);
  assign load_first  = accept && (kind == KIND_LOAD_FIRST);
  assign load_second = accept && (kind == KIND_LOAD_SECOND);
  // merge needs at least one element, otherwise only the flag clears
  assign merge_empty = (first_count == '0) && (second_count == '0);
  assign merge_go    = accept && (kind == KIND_MERGE) && !merge_empty;

  // list counts and sticky drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      dropped      <= 1'b0;
    end else begin
      if (rd_ctl.done) begin
        first_count  <= '0;
        second_count <= '0;
        dropped      <= 1'b0;
      end else if (accept && (kind == KIND_MERGE) && merge_empty) begin
        dropped <= 1'b0;
      end else if (load_first) begin
        if (first_full) begin
          dropped <= 1'b1;
        end else begin
          first_count <= first_count + CNT_W'(1);
        end
      end else if (load_second) begin
        if (second_full) begin
          dropped <= 1'b1;
        end else begin
          second_count <= second_count + CNT_W'(1);
        end
      end
    end
  end

  // one ram per list: appends write at the count, the merge reads heads
  slm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(LIST_DEPTH)
  ) u_first_ram (
    .clk  (clk),
    .we   (load_first && !first_full),
    .waddr(first_count[ADDR_W-1:0]),
    .wdata(value),
    .re   (rd_ctl.first_en),
    .raddr(rd_ctl.first_addr),
    .rdata(head_first)
  );

  slm_ram #(
    .WIDTH(DATA_W),
    .DEPTH(LIST_DEPTH)
  ) u_second_ram (
    .clk  (clk),
    .we   (load_second && !second_full),
    .waddr(second_count[ADDR_W-1:0]),
    .wdata(value),
    .re   (rd_ctl.second_en),
    .raddr(rd_ctl.second_addr),
    .rdata(head_second)
  );

  // compare, select and output register
  slm_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (merge_go),
    .first_count (first_count),
    .second_count(second_count),
    .dropped     (dropped),
    .head_first  (head_first),
    .head_second (head_second),
    .out_ready   (out_ready),
    .rd_ctl      (rd_ctl),
    .busy        (busy),
    .out_valid   (out_valid),
    .merged_value(merged_value),
    .from_second (from_second),
    .last        (last),
    .overflow    (overflow)
  );

  // counts never pass the list depth
  `SLM_ASSERT_NOW(a_count_bound, clk, rst, 1'b1,
    (first_count <= CNT_W'(LIST_DEPTH)) && (second_count <= CNT_W'(LIST_DEPTH)))
  // a non-empty merge takes the input side off
  `SLM_ASSERT_NEXT(a_merge_busy, clk, rst, merge_go, !in_ready)
  // lists and flag are empty after the final element
  `SLM_ASSERT_NEXT(a_done_clears, clk, rst, rd_ctl.done,
    (first_count == '0) && (second_count == '0) && !dropped && out_valid && last)

endmodule
